/* rtl/tfs_pkg.sv */
package tfs_pkg;

   localparam int MaxFpBytes   = 128;
   localparam int PosWidth     = $clog2(MaxFpBytes);
   localparam int LenWidth     = 8;
   localparam int CountWidth   = 11;
   localparam int UnionWidth   = CountWidth + 1;
   localparam int SimWidth     = 17;
   localparam int FracBits     = 16;
   localparam int DividendBits = CountWidth + FracBits;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = QueuePtrBits + 1;

   localparam logic [LenWidth-1:0] DefaultFpBytes = LenWidth'(MaxFpBytes);

   localparam logic ActionQuery = 1'b0;
   localparam logic ActionDb    = 1'b1;

   typedef struct packed {
      logic [CountWidth-1:0] query_ones;
      logic [CountWidth-1:0] db_ones;
      logic [CountWidth-1:0] common_ones;
   } rec_type;

   function automatic logic [3:0] ones_in_byte(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int b = 0; b < 8; b++) begin
         n = n + {3'd0, v[b]};
      end
      return n;
   endfunction

endpackage

/* rtl/tfs_front.sv */
module tfs_front import tfs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_action,
   input  logic [7:0]              req_fp_byte,
   input  logic [LenWidth-1:0]     fp_bytes,
   input  logic [QueueCntBits-1:0] queue_level,
   output logic                    rec_push,
   output rec_type                 rec_data
);

   logic [7:0] query_store [MaxFpBytes];
   logic [7:0] store_rd_ff;

   logic [PosWidth-1:0]   query_pos_ff, query_pos_in;
   logic [PosWidth-1:0]   db_pos_ff, db_pos_in;
   logic [CountWidth-1:0] query_ones_ff, query_ones_in;

   // second stage: database byte meets the stored query byte
   logic                  b_valid_ff, b_valid_in;
   logic [7:0]            b_byte_ff;
   logic                  b_first_ff;
   logic                  b_last_ff;
   logic [CountWidth-1:0] b_qones_ff;

   logic [CountWidth-1:0] db_ones_ff, db_ones_in;
   logic [CountWidth-1:0] common_ones_ff, common_ones_in;

   logic                accept;
   logic [LenWidth-1:0] len;
   logic [PosWidth-1:0] pos;
   logic                pos_last;
   logic [3:0]          byte_ones;
   logic [3:0]          and_ones;
   logic                b_push;

   assign b_push = b_valid_ff & b_last_ff;
   // room for the record in the second stage and one more
   assign full   = ({1'b0, queue_level} + {{QueueCntBits{1'b0}}, b_push})
                   >= (QueueCntBits + 1)'(QueueDepth);
   assign accept = push & ~full;

   always_comb begin
      if (fp_bytes == '0 || fp_bytes > LenWidth'(MaxFpBytes)) begin
         len = LenWidth'(MaxFpBytes);
      end else begin
         len = fp_bytes;
      end
   end

   assign pos       = (req_action == ActionQuery) ? query_pos_ff : db_pos_ff;
   assign pos_last  = (LenWidth'(pos) + LenWidth'(1)) >= len;
   assign byte_ones = ones_in_byte(req_fp_byte);

   always_comb begin
      query_pos_in  = query_pos_ff;
      db_pos_in     = db_pos_ff;
      query_ones_in = query_ones_ff;
      b_valid_in    = 1'b0;
      if (accept) begin
         if (req_action == ActionQuery) begin
            if (pos == '0) begin
               query_ones_in = CountWidth'(byte_ones);
            end else begin
               query_ones_in = query_ones_ff + CountWidth'(byte_ones);
            end
            query_pos_in = pos_last ? '0 : pos + PosWidth'(1);
            db_pos_in    = '0;
         end else begin
            b_valid_in = 1'b1;
            db_pos_in  = pos_last ? '0 : pos + PosWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_action == ActionQuery) begin
         query_store[pos] <= req_fp_byte;
      end
      store_rd_ff <= query_store[pos];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_byte_ff  <= req_fp_byte;
         b_first_ff <= (pos == '0);
         b_last_ff  <= pos_last;
         b_qones_ff <= query_ones_ff;
      end
   end

   assign and_ones = ones_in_byte(b_byte_ff & store_rd_ff);

   always_comb begin
      db_ones_in     = db_ones_ff;
      common_ones_in = common_ones_ff;
      if (b_valid_ff) begin
         db_ones_in     = (b_first_ff ? '0 : db_ones_ff)
                          + CountWidth'(ones_in_byte(b_byte_ff));
         common_ones_in = (b_first_ff ? '0 : common_ones_ff) + CountWidth'(and_ones);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_pos_ff   <= '0;
         db_pos_ff      <= '0;
         query_ones_ff  <= '0;
         b_valid_ff     <= 1'b0;
         db_ones_ff     <= '0;
         common_ones_ff <= '0;
      end else begin
         query_pos_ff   <= query_pos_in;
         db_pos_ff      <= db_pos_in;
         query_ones_ff  <= query_ones_in;
         b_valid_ff     <= b_valid_in;
         db_ones_ff     <= db_ones_in;
         common_ones_ff <= common_ones_in;
      end
   end

   assign rec_push             = b_push;
   assign rec_data.query_ones  = b_qones_ff;
   assign rec_data.db_ones     = db_ones_in;
   assign rec_data.common_ones = common_ones_in;

endmodule

/* rtl/tfs_queue.sv */
module tfs_queue import tfs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  rec_type                 wr_data,
   input  logic                    rd_en,
   output rec_type                 rd_data,
   output logic                    q_empty,
   output logic [QueueCntBits-1:0] level
);

   rec_type entries [QueueDepth];

   logic [QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0] count_ff, count_in;
   logic                    do_rd;

   assign q_empty = (count_ff == '0);
   assign do_rd   = rd_en & ~q_empty;
   assign rd_data = entries[rd_ptr_ff];
   assign level   = count_ff;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + QueuePtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QueuePtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntBits'(wr_en) - QueueCntBits'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/tfs_back.sv */
module tfs_back import tfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  rec_type               rec_data,
   input  logic                  rec_empty,
   output logic                  rec_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic [SimWidth-1:0]   rsp_similarity_q16,
   output logic [CountWidth-1:0] rsp_common_bits,
   output logic [CountWidth-1:0] rsp_union_bits,
   output logic                  rsp_empty_union
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StDone = 2'd2;

   localparam int StepBits = $clog2(DividendBits);

   logic [1:0]              state_ff, state_in;
   logic [StepBits-1:0]     step_ff, step_in;
   logic [UnionWidth-1:0]   uni_ff, uni_in;
   logic [CountWidth-1:0]   common_ff, common_in;
   logic [DividendBits-1:0] num_ff, num_in;
   logic [UnionWidth-1:0]   rem_ff, rem_in;
   logic [SimWidth-1:0]     quo_ff, quo_in;

   logic                    out_valid_ff, out_valid_in;
   logic [SimWidth-1:0]     out_sim_ff;
   logic [CountWidth-1:0]   out_common_ff;
   logic [CountWidth-1:0]   out_union_ff;
   logic                    out_empty_ff;

   logic [UnionWidth-1:0]   load_uni;
   logic [UnionWidth:0]     rem_shift;
   logic                    rem_ge;
   logic                    slot_free;
   logic                    out_load;

   assign load_uni = {1'b0, rec_data.query_ones} + {1'b0, rec_data.db_ones}
                     - {1'b0, rec_data.common_ones};

   // restoring division, one quotient bit per cycle
   assign rem_shift = {rem_ff, num_ff[DividendBits-1]};
   assign rem_ge    = rem_shift >= {1'b0, uni_ff};

   assign slot_free = ~out_valid_ff | pop;
   assign out_load  = (state_ff == StDone) & slot_free;
   assign rec_pop   = (state_ff == StIdle) & ~rec_empty;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      uni_in    = uni_ff;
      common_in = common_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      case (state_ff)
         StIdle: begin
            if (!rec_empty) begin
               uni_in    = load_uni;
               common_in = rec_data.common_ones;
               num_in    = {rec_data.common_ones, {FracBits{1'b0}}};
               rem_in    = '0;
               quo_in    = '0;
               step_in   = '0;
               state_in  = (load_uni == '0) ? StDone : StDiv;
            end
         end
         StDiv: begin
            if (rem_ge) begin
               rem_in = UnionWidth'(rem_shift - {1'b0, uni_ff});
            end else begin
               rem_in = UnionWidth'(rem_shift);
            end
            quo_in  = {quo_ff[SimWidth-2:0], rem_ge};
            num_in  = {num_ff[DividendBits-2:0], 1'b0};
            step_in = step_ff + StepBits'(1);
            if (step_ff == StepBits'(DividendBits - 1)) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (slot_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      uni_ff    <= uni_in;
      common_ff <= common_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      if (out_load) begin
         out_sim_ff    <= quo_ff;
         out_common_ff <= common_ff;
         out_union_ff  <= uni_ff[CountWidth-1:0];
         out_empty_ff  <= (uni_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty              = ~out_valid_ff;
   assign rsp_similarity_q16 = out_sim_ff;
   assign rsp_common_bits    = out_common_ff;
   assign rsp_union_bits     = out_union_ff;
   assign rsp_empty_union    = out_empty_ff;

endmodule

/* rtl/tanimoto_fingerprint_similarity_core.sv */
// a final database byte's record passes the queue, the divider and the output register
// throughput: one fingerprint byte per cycle while full is low; the back end divides
// with one quotient bit per cycle and takes no new record until its result is loaded
// a four-entry queue between the byte counter and the divider absorbs bursts of records
// reset: synchronous active-high; clears positions, counts, queue and output,
// fingerprint length returns to 128 bytes; the query store is left as is
module tanimoto_fingerprint_similarity_core import tfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_action,
   input  logic [7:0]            req_fp_byte,
   output logic                  empty,
   input  logic                  pop,
   output logic [SimWidth-1:0]   rsp_similarity_q16,
   output logic [CountWidth-1:0] rsp_common_bits,
   output logic [CountWidth-1:0] rsp_union_bits,
   output logic                  rsp_empty_union,
   input  logic                  csr_write_enable,
   input  logic [LenWidth-1:0]   csr_write_data
);

   logic [LenWidth-1:0]     fp_bytes_ff;
   logic                    rec_push;
   rec_type                 rec_wr;
   rec_type                 rec_rd;
   logic                    rec_pop;
   logic                    rec_empty;
   logic [QueueCntBits-1:0] queue_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_bytes_ff <= DefaultFpBytes;
      end else if (csr_write_enable) begin
         fp_bytes_ff <= csr_write_data;
      end
   end

   tfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_action  (req_action),
      .req_fp_byte (req_fp_byte),
      .fp_bytes    (fp_bytes_ff),
      .queue_level (queue_level),
      .rec_push    (rec_push),
      .rec_data    (rec_wr)
   );

   tfs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_push),
      .wr_data (rec_wr),
      .rd_en   (rec_pop),
      .rd_data (rec_rd),
      .q_empty (rec_empty),
      .level   (queue_level)
   );

   tfs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .rec_data           (rec_rd),
      .rec_empty          (rec_empty),
      .rec_pop            (rec_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_similarity_q16 (rsp_similarity_q16),
      .rsp_common_bits    (rsp_common_bits),
      .rsp_union_bits     (rsp_union_bits),
      .rsp_empty_union    (rsp_empty_union)
   );

endmodule
